// ----- rtl/core/bba_pkg.sv -----
package bba_pkg;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_SIZE = 2'd2
	} status_t;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam int unsigned CFG_POOL_SIZE = 0;
	localparam int unsigned CFG_BASE_ADDR = 1;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// ----- rtl/core/bba_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bba_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::div_req_t req,
	output bba_pkg::div_rsp_t rsp
);

	logic [31:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], quo_q[31]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				if (!diff[32]) begin
					rem_q <= diff;
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/core/buddy_bitmap_allocator.sv -----
// Buddy allocator over a pool of pool_size bytes at base_address.
// Slave channel s_axis_*: one request per transfer, tuser = action,
// tdata = {free_address, request_size} from the high bit down.
// Master channel m_axis_*: one result per request, tdata = {block_level,
// block_address, status} from the high bit down (status bits 1:0).
// Configuration: cfg_we/cfg_index/cfg_data, write only while idle.
// Steps from request transfer to m_axis_tvalid, block at level l:
//   allocate: level steps, then a search for the first clear node at level l,
//   then the subtree marks, the ancestor marks and the output register.
//   A full level goes from the search straight to the output register.
//   free: the serial divider maps the address to a leaf, then the level read,
//   the subtree clears, the ancestor clears up to the first busy buddy and
//   the output register.
//   A rejected request goes straight to the output register (a free whose
//   leaf lies past the pool only after the divider).
// One request is in flight at a time; the next is taken the cycle after
// the result is loaded. A stalled result waits in the output register while
// the next request is processed; that one waits until the first transfers.
// Reset clears the whole tree (pool free), pool_size to 4096, base to 0.
module buddy_bitmap_allocator #(
	parameter int LEVELS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic        s_axis_tuser,  // action
	input  logic [63:0] s_axis_tdata,  // request_size, free_address
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // status, block_address, block_level
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NODES = (1 << LEVELS) - 1;
	localparam int LEAVES = 1 << (LEVELS - 1);
	localparam int LW = (LEVELS > 1) ? LEVELS - 1 : 1;
	localparam int NW = LEVELS;

	typedef enum logic [3:0] {
		S_IDLE, S_LEVEL, S_SEARCH, S_MARK, S_UP, S_DIV, S_FREE_RD, S_FREE_UP, S_OUT
	} state_t;

	state_t       state_q;
	logic [31:0]  pool_q, base_q;
	logic [NODES-1:0] tree_q;
	logic [2:0]   lol_q [LEAVES];
	logic [31:0]  req_q;
	logic [32:0]  bsize_q;
	logic [2:0]   lvl_q;
	logic [NW-1:0] node_q;   // node within level
	logic [NW-1:0] mlvl_q;   // sweep level
	logic [NW:0]  mcnt_q;
	logic [NW-1:0] mfirst_q;
	logic         mval_q;
	logic [1:0]   status_q;
	logic [31:0]  addr_q;
	logic [36:0]  res_q;
	logic         ovalid_q;

	logic [31:0] leaf_size;
	logic [32:0] usable;
	bba_pkg::div_req_t dreq;
	bba_pkg::div_rsp_t drsp;

	assign leaf_size = pool_q >> (LEVELS - 1);
	assign usable    = {1'b0, leaf_size} << (LEVELS - 1);

	bba_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign dreq.start    = (state_q == S_IDLE) && s_axis_tvalid
		&& s_axis_tuser == bba_pkg::ACT_FREE && leaf_size != 32'd0;
	assign dreq.dividend = s_axis_tdata[63:32] - 32'd1 - base_q;
	assign dreq.divisor  = leaf_size;

	function automatic logic [NW-1:0] hidx(input logic [NW-1:0] l, input logic [NW-1:0] n);
		logic [NW:0] i;
		i = ({{NW{1'b0}}, 1'b1} << l) - 1'b1 + {1'b0, n};
		return (i < (NW+1)'(NODES)) ? i[NW-1:0] : '0;
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {3'd0, res_q};

	logic [NW-1:0] buddy_idx;
	assign buddy_idx = hidx(NW'(lvl_q), node_q ^ NW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pool_q   <= 32'd4096;
			base_q   <= '0;
			tree_q   <= '0;
			res_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(bba_pkg::CFG_POOL_SIZE)) pool_q <= cfg_data;
				else base_q <= cfg_data;
			end
			// S_OUT handles the output register itself
			if (ovalid_q && m_axis_tready && state_q != S_OUT) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q    <= s_axis_tdata[31:0];
						lvl_q    <= '0;
						addr_q   <= '0;
						status_q <= bba_pkg::ST_DONE;
						bsize_q  <= usable;
						node_q   <= '0;
						if (s_axis_tuser == bba_pkg::ACT_ALLOC) begin
							if (s_axis_tdata[31:0] == 32'd0 ||
							    {1'b0, s_axis_tdata[31:0]} > usable) begin
								status_q <= bba_pkg::ST_BAD_SIZE;
								state_q  <= S_OUT;
							end else state_q <= S_LEVEL;
						end else if (leaf_size == 32'd0) begin
							status_q <= bba_pkg::ST_BAD_SIZE;
							state_q  <= S_OUT;
						end else state_q <= S_DIV;
					end
				end
				S_LEVEL: begin
					if (bsize_q > {1'b0, leaf_size} && (bsize_q >> 1) > {1'b0, req_q}
					    && 32'(lvl_q) < LEVELS - 1) begin
						lvl_q   <= lvl_q + 3'd1;
						bsize_q <= bsize_q >> 1;
					end else state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					if (!tree_q[hidx(NW'(lvl_q), node_q)]) begin
						mlvl_q   <= NW'(lvl_q);
						mfirst_q <= node_q;
						mcnt_q   <= '0;
						mval_q   <= 1'b1;
						addr_q   <= base_q + 32'(node_q) * bsize_q[31:0] + 32'd1;
						lol_q[LW'(node_q << (LEVELS - 1 - 32'(lvl_q)))] <= lvl_q;
						state_q  <= S_MARK;
					end else if ({1'b0, node_q} == ((NW+1)'(1) << lvl_q) - 1'b1) begin
						status_q <= bba_pkg::ST_FULL;
						state_q  <= S_OUT;
					end else node_q <= node_q + 1'b1;
				end
				S_MARK: begin
					tree_q[hidx(mlvl_q, mfirst_q + NW'(mcnt_q))] <= mval_q;
					if (mcnt_q == ((NW+1)'(1) << (mlvl_q - NW'(lvl_q))) - 1'b1) begin
						mcnt_q <= '0;
						if (32'(mlvl_q) == LEVELS - 1) begin
							mlvl_q  <= NW'(lvl_q);
							state_q <= mval_q ? S_UP : S_FREE_UP;
						end else begin
							mlvl_q   <= mlvl_q + 1'b1;
							mfirst_q <= mfirst_q << 1;
						end
					end else mcnt_q <= mcnt_q + 1'b1;
				end
				S_UP: begin
					if (mlvl_q == '0) state_q <= S_OUT;
					else begin
						mlvl_q   <= mlvl_q - 1'b1;
						mfirst_q <= (mlvl_q == NW'(lvl_q) ? node_q : mfirst_q) >> 1;
						tree_q[hidx(mlvl_q - 1'b1,
							(mlvl_q == NW'(lvl_q) ? node_q : mfirst_q) >> 1)] <= 1'b1;
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						if (drsp.quotient >= 32'(LEAVES)) begin
							status_q <= bba_pkg::ST_BAD_SIZE;
							state_q  <= S_OUT;
						end else begin
							node_q  <= NW'(drsp.quotient);
							state_q <= S_FREE_RD;
						end
					end
				end
				S_FREE_RD: begin
					logic [2:0] l;
					l = lol_q[LW'(node_q)];
					if (32'(l) > LEVELS - 1) l = 3'(LEVELS - 1);
					lvl_q    <= l;
					node_q   <= node_q >> (LEVELS - 1 - 32'(l));
					mfirst_q <= node_q >> (LEVELS - 1 - 32'(l));
					mlvl_q   <= NW'(l);
					mcnt_q   <= '0;
					mval_q   <= 1'b0;
					state_q  <= S_MARK;
				end
				S_FREE_UP: begin
					// lvl_q reused as walking level; block level saved in mlvl_q
					if (lvl_q != '0 && !tree_q[buddy_idx]) begin
						lvl_q  <= lvl_q - 3'd1;
						node_q <= node_q >> 1;
						tree_q[hidx(NW'(lvl_q - 3'd1), node_q >> 1)] <= 1'b0;
					end else begin
						lvl_q   <= 3'(mlvl_q);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ovalid_q || m_axis_tready) begin
						res_q    <= {lvl_q, addr_q, status_q};
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
